// ===== rtl/cms_pkg.sv =====
`default_nettype none
package cms_pkg;

  localparam int NUM_BUILTIN = 19;
  localparam logic [4:0] MAP_GRAY   = 5'd0;
  localparam logic [4:0] MAP_CUSTOM = 5'd19;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_SELECT    = 3'd0,
    REG_REVERSE_ORDER = 3'd1,
    REG_ANCHOR_COUNT  = 3'd2,
    REG_PAIR_0        = 3'd3,
    REG_PAIR_1        = 3'd4,
    REG_PAIR_2        = 3'd5,
    REG_PAIR_3        = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_reg_t;

  localparam int CFG_DATA_W = 48;
  localparam int RGB_W = 24;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Anchor count of each built-in map; unused codes fall back to grayscale.
  function automatic logic [3:0] builtin_count(input logic [4:0] sel);
    logic [3:0] c;
    case (sel)
      5'd1: c = 4'd10;
      5'd2, 5'd3, 5'd4: c = 4'd9;
      5'd5, 5'd6: c = 4'd8;
      5'd7: c = 4'd6;
      5'd8: c = 4'd4;
      5'd9: c = 4'd2;
      5'd10, 5'd11, 5'd12, 5'd13: c = 4'd8;
      5'd14, 5'd15, 5'd16, 5'd17: c = 4'd11;
      5'd18: c = 4'd7;
      default: c = 4'd2;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] pk(input int r, input int g, input int b);
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  // Anchor k of built-in map sel; k beyond the map's count is never used.
  function automatic logic [23:0] builtin_anchor(input logic [4:0] sel, input logic [3:0] k);
    logic [23:0] v;
    v = 24'h0;
    case (sel)
      5'd1: case (k)
        4'd0: v = pk(68,1,84);     4'd1: v = pk(72,40,120);   4'd2: v = pk(62,73,137);
        4'd3: v = pk(49,104,142);  4'd4: v = pk(38,130,142);  4'd5: v = pk(31,158,137);
        4'd6: v = pk(53,183,121);  4'd7: v = pk(110,206,88);  4'd8: v = pk(181,222,43);
        default: v = pk(253,231,37);
      endcase
      5'd2: case (k)
        4'd0: v = pk(0,0,4);       4'd1: v = pk(31,12,72);    4'd2: v = pk(85,15,109);
        4'd3: v = pk(136,34,106);  4'd4: v = pk(186,54,85);   4'd5: v = pk(227,89,51);
        4'd6: v = pk(249,140,10);  4'd7: v = pk(249,201,50);
        default: v = pk(252,255,164);
      endcase
      5'd3: case (k)
        4'd0: v = pk(0,0,4);       4'd1: v = pk(28,16,68);    4'd2: v = pk(79,18,123);
        4'd3: v = pk(129,37,129);  4'd4: v = pk(181,54,122);  4'd5: v = pk(229,80,100);
        4'd6: v = pk(251,135,97);  4'd7: v = pk(254,194,135);
        default: v = pk(252,253,191);
      endcase
      5'd4: case (k)
        4'd0: v = pk(13,8,135);    4'd1: v = pk(75,3,161);    4'd2: v = pk(125,3,168);
        4'd3: v = pk(168,34,150);  4'd4: v = pk(203,70,121);  4'd5: v = pk(229,107,93);
        4'd6: v = pk(248,148,65);  4'd7: v = pk(253,195,40);
        default: v = pk(240,249,33);
      endcase
      5'd5: case (k)
        4'd0: v = pk(0,34,78);     4'd1: v = pk(38,62,110);   4'd2: v = pk(73,82,112);
        4'd3: v = pk(108,103,109); 4'd4: v = pk(146,123,103); 4'd5: v = pk(187,145,87);
        4'd6: v = pk(225,170,61);
        default: v = pk(255,221,57);
      endcase
      5'd6: case (k)
        4'd0: v = pk(48,18,59);    4'd1: v = pk(64,90,210);   4'd2: v = pk(28,168,232);
        4'd3: v = pk(36,231,138);  4'd4: v = pk(166,249,40);  4'd5: v = pk(250,186,30);
        4'd6: v = pk(232,79,12);
        default: v = pk(122,4,3);
      endcase
      5'd7: case (k)
        4'd0: v = pk(0,0,128);     4'd1: v = pk(0,0,255);     4'd2: v = pk(0,255,255);
        4'd3: v = pk(255,255,0);   4'd4: v = pk(255,0,0);
        default: v = pk(128,0,0);
      endcase
      5'd8: case (k)
        4'd0: v = pk(0,0,0);       4'd1: v = pk(255,0,0);     4'd2: v = pk(255,255,0);
        default: v = pk(255,255,255);
      endcase
      5'd9: case (k)
        4'd0: v = pk(0,255,255);
        default: v = pk(255,0,255);
      endcase
      5'd10: case (k)
        4'd0: v = pk(247,251,255); 4'd1: v = pk(198,219,239); 4'd2: v = pk(158,202,225);
        4'd3: v = pk(107,174,214); 4'd4: v = pk(66,146,198);  4'd5: v = pk(33,113,181);
        4'd6: v = pk(8,81,156);
        default: v = pk(8,48,107);
      endcase
      5'd11: case (k)
        4'd0: v = pk(247,252,245); 4'd1: v = pk(199,233,192); 4'd2: v = pk(161,217,155);
        4'd3: v = pk(116,196,118); 4'd4: v = pk(65,171,93);   4'd5: v = pk(35,139,69);
        4'd6: v = pk(0,109,44);
        default: v = pk(0,68,27);
      endcase
      5'd12: case (k)
        4'd0: v = pk(255,245,240); 4'd1: v = pk(252,187,161); 4'd2: v = pk(252,146,114);
        4'd3: v = pk(251,106,74);  4'd4: v = pk(239,59,44);   4'd5: v = pk(203,24,29);
        4'd6: v = pk(165,15,21);
        default: v = pk(103,0,13);
      endcase
      5'd13: case (k)
        4'd0: v = pk(255,245,235); 4'd1: v = pk(253,208,162); 4'd2: v = pk(253,174,107);
        4'd3: v = pk(253,141,60);  4'd4: v = pk(241,105,19);  4'd5: v = pk(217,72,1);
        4'd6: v = pk(166,54,3);
        default: v = pk(127,39,4);
      endcase
      5'd14: case (k)
        4'd0: v = pk(158,1,66);    4'd1: v = pk(213,62,79);   4'd2: v = pk(244,109,67);
        4'd3: v = pk(253,174,97);  4'd4: v = pk(254,224,139); 4'd5: v = pk(255,255,191);
        4'd6: v = pk(230,245,152); 4'd7: v = pk(171,221,164); 4'd8: v = pk(102,194,165);
        4'd9: v = pk(50,136,189);
        default: v = pk(94,79,162);
      endcase
      5'd15: case (k)
        4'd0: v = pk(103,0,31);    4'd1: v = pk(178,24,43);   4'd2: v = pk(214,96,77);
        4'd3: v = pk(244,165,130); 4'd4: v = pk(253,219,199); 4'd5: v = pk(247,247,247);
        4'd6: v = pk(209,229,240); 4'd7: v = pk(146,197,222); 4'd8: v = pk(67,147,195);
        4'd9: v = pk(33,102,172);
        default: v = pk(5,48,97);
      endcase
      5'd16: case (k)
        4'd0: v = pk(165,0,38);    4'd1: v = pk(215,48,39);   4'd2: v = pk(244,109,67);
        4'd3: v = pk(253,174,97);  4'd4: v = pk(254,224,144); 4'd5: v = pk(255,255,191);
        4'd6: v = pk(224,243,248); 4'd7: v = pk(171,217,233); 4'd8: v = pk(116,173,209);
        4'd9: v = pk(69,117,180);
        default: v = pk(49,54,149);
      endcase
      5'd17: case (k)
        4'd0: v = pk(165,0,38);    4'd1: v = pk(215,48,39);   4'd2: v = pk(244,109,67);
        4'd3: v = pk(253,174,97);  4'd4: v = pk(254,224,139); 4'd5: v = pk(255,255,191);
        4'd6: v = pk(217,239,139); 4'd7: v = pk(166,217,106); 4'd8: v = pk(102,189,99);
        4'd9: v = pk(26,152,80);
        default: v = pk(0,104,55);
      endcase
      5'd18: case (k)
        4'd0: v = pk(59,76,192);   4'd1: v = pk(124,159,249); 4'd2: v = pk(192,212,245);
        4'd3: v = pk(242,242,242); 4'd4: v = pk(246,194,165); 4'd5: v = pk(222,96,77);
        default: v = pk(180,4,38);
      endcase
      default: case (k)
        4'd0: v = pk(0,0,0);
        default: v = pk(255,255,255);
      endcase
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cms_stream_if.sv =====
`default_nettype none
interface cms_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cms_cfg_if.sv =====
`default_nettype none
interface cms_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cms_regs.sv =====
`default_nettype none
module cms_regs #(
  parameter int MAX_CUSTOM_ANCHORS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  cms_cfg_if.sink   cfg,
  output logic [4:0]  map_select,
  output logic        reverse_order,
  output logic [3:0]  anchor_count,
  output logic [7:0][23:0] anchors
);
  import cms_pkg::*;

  logic [3:0][47:0] pair;
  logic [3:0] count_raw;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_select    <= MAP_GRAY;
      reverse_order <= 1'b0;
      count_raw     <= '0;
      pair          <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_MAP_SELECT:    map_select    <= cfg.data[4:0];
        REG_REVERSE_ORDER: reverse_order <= cfg.data[0];
        REG_ANCHOR_COUNT:  count_raw     <= cfg.data[3:0];
        REG_PAIR_0:        pair[0]       <= cfg.data;
        REG_PAIR_1:        pair[1]       <= cfg.data;
        REG_PAIR_2:        pair[2]       <= cfg.data;
        REG_PAIR_3:        pair[3]       <= cfg.data;
        default: ;
      endcase
    end
  end

  // saturate the count to the number of anchor slots
  assign anchor_count = (count_raw > 4'(MAX_CUSTOM_ANCHORS)) ? 4'(MAX_CUSTOM_ANCHORS)
                                                             : count_raw;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      anchors[2*k]   = pair[k][23:0];
      anchors[2*k+1] = pair[k][47:24];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cms_blend.sv =====
`default_nettype none
// One colour channel: x + (y-x)*f, rounded half up, two register stages.
module cms_blend #(
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [7:0] x,
  input  wire logic [7:0] y,
  input  wire logic [T_FRAC_BITS-1:0] f,
  output logic [7:0] z
);
  localparam int PW = T_FRAC_BITS + 10;

  logic signed [PW-1:0] prod;
  logic [7:0] x_q;
  logic signed [PW-1:0] acc;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'($signed({1'b0, y}) - $signed({1'b0, x})) * $signed(PW'({1'b0, f}));
      x_q  <= x;
    end
  end

  always_comb begin
    acc = prod + $signed(PW'({x_q, {T_FRAC_BITS{1'b0}}}))
               + $signed(PW'(1) <<< (T_FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (en) z <= acc[T_FRAC_BITS +: 8];
  end
endmodule
`default_nettype wire

// ===== rtl/colormap_sampler.sv =====
`default_nettype none
// Colour map sampler.
// in_ch carries t_value (signed, T_FRAC_BITS fraction bits); out_ch carries
// {red, green, blue} with red highest. cfg takes register writes (index,
// data) and is always ready; write it only while the pipeline is empty.
// An input beat is clamped to [0,1], optionally reversed, scaled by the
// anchor count minus one, turned into an anchor pair and blended per channel.
// Pipeline: clamp/scale multiply, index/anchor fetch, blend multiply,
// blend sum into the output register: four stages. One beat per cycle is
// sustained while the receiver takes every result.
// The pipeline advances as a whole whenever its last stage is empty or
// being taken; a receiver stall holds every stage and drops in_ch ready.
// Reset clears all valid bits and the registers (grayscale, not reversed,
// no custom anchors); payload registers are not reset.
module colormap_sampler #(
  parameter int MAX_CUSTOM_ANCHORS = 8,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  cms_stream_if.sink   in_ch,
  cms_stream_if.source out_ch,
  cms_cfg_if.sink      cfg
);
  import cms_pkg::*;

  localparam int TW = T_FRAC_BITS + 2;
  localparam int SW = T_FRAC_BITS + 5;

  logic [4:0]  map_select;
  logic        reverse_order;
  logic [3:0]  anchor_count;
  logic [7:0][23:0] anchors;

  cms_regs #(.MAX_CUSTOM_ANCHORS(MAX_CUSTOM_ANCHORS)) u_regs (
    .clk, .rst, .cfg, .map_select, .reverse_order, .anchor_count, .anchors
  );

  logic [3:0] vld;
  logic adv;
  assign adv = !vld[3] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[2:0], in_ch.valid};
  end

  // stage 0: clamp, reverse, choose count
  logic signed [TW-1:0] t_in;
  logic [T_FRAC_BITS:0] t_cl;
  logic use_custom;
  logic [3:0] n_sel;
  assign t_in = $signed(in_ch.data[TW-1:0]);
  always_comb begin
    if (t_in[TW-1]) t_cl = '0;
    else if (t_in > $signed(TW'(1) <<< T_FRAC_BITS)) t_cl = {1'b1, {T_FRAC_BITS{1'b0}}};
    else t_cl = t_in[T_FRAC_BITS:0];
    if (reverse_order) t_cl = {1'b1, {T_FRAC_BITS{1'b0}}} - t_cl;
    use_custom = (map_select == MAP_CUSTOM) && (anchor_count >= 4'd2);
    n_sel = use_custom ? anchor_count : builtin_count(map_select);
  end

  logic [SW-1:0] s1_scaled;
  logic [3:0] s1_n;
  logic s1_cust;
  logic [4:0] s1_sel;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_scaled <= SW'(t_cl) * SW'(n_sel - 4'd1);
      s1_n      <= n_sel;
      s1_cust   <= use_custom;
      s1_sel    <= map_select;
    end
  end

  // stage 1: split index and fraction, fetch anchor pair
  logic [4:0] idx;
  logic [3:0] i_a, i_b;
  logic [T_FRAC_BITS-1:0] fr;
  logic [23:0] a_rgb, b_rgb;
  always_comb begin
    idx = s1_scaled[SW-1 -: 5];
    if (idx >= 5'({1'b0, s1_n} - 5'd1)) begin
      i_a = s1_n - 4'd1;
      fr  = '0;
    end else begin
      i_a = idx[3:0];
      fr  = s1_scaled[T_FRAC_BITS-1:0];
    end
    i_b = (i_a + 4'd1 < s1_n) ? i_a + 4'd1 : i_a;
    if (s1_cust) begin
      a_rgb = anchors[i_a[2:0]];
      b_rgb = anchors[i_b[2:0]];
    end else begin
      a_rgb = builtin_anchor(s1_sel, i_a);
      b_rgb = builtin_anchor(s1_sel, i_b);
    end
  end

  rgb_t s2_a, s2_b;
  logic [T_FRAC_BITS-1:0] s2_f;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a <= a_rgb;
      s2_b <= b_rgb;
      s2_f <= fr;
    end
  end

  // stage 2: blend multiply; stage 3: blend sum into the output register
  rgb_t res;
  cms_blend #(.T_FRAC_BITS(T_FRAC_BITS)) u_r (
    .clk, .en(adv), .x(s2_a.r), .y(s2_b.r), .f(s2_f), .z(res.r));
  cms_blend #(.T_FRAC_BITS(T_FRAC_BITS)) u_g (
    .clk, .en(adv), .x(s2_a.g), .y(s2_b.g), .f(s2_f), .z(res.g));
  cms_blend #(.T_FRAC_BITS(T_FRAC_BITS)) u_b (
    .clk, .en(adv), .x(s2_a.b), .y(s2_b.b), .f(s2_f), .z(res.b));

  assign out_ch.valid = vld[3];
  assign out_ch.data  = res;

  // hold: a stalled output keeps its valid bit
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output valid dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted beat lost at pipeline entry");
endmodule
`default_nettype wire

// ===== tb/colormap_sampler_checker.sv =====
module colormap_sampler_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire logic [17:0] in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire logic [23:0] out_data,
  input  wire logic cfg_valid,
  input  wire logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [47:0] cfg_data,
  output int fail_count,
  output int colours_pending
);
  import cms_pkg::*;

  localparam int ONE = 65536;

  logic [4:0]  sel_q;
  logic        rev_q;
  logic [3:0]  count_q;
  logic [47:0] pairs_q [4];
  rgb_t        colour_q [$];

  function automatic logic [23:0] table_colour(input logic [4:0] sel, input int k);
    logic [23:0] v;
    v = 24'h0;
    case (sel)
      5'd1: case (k)
        0: v = {8'd68,8'd1,8'd84};     1: v = {8'd72,8'd40,8'd120};
        2: v = {8'd62,8'd73,8'd137};   3: v = {8'd49,8'd104,8'd142};
        4: v = {8'd38,8'd130,8'd142};  5: v = {8'd31,8'd158,8'd137};
        6: v = {8'd53,8'd183,8'd121};  7: v = {8'd110,8'd206,8'd88};
        8: v = {8'd181,8'd222,8'd43};  default: v = {8'd253,8'd231,8'd37};
      endcase
      5'd2: case (k)
        0: v = {8'd0,8'd0,8'd4};       1: v = {8'd31,8'd12,8'd72};
        2: v = {8'd85,8'd15,8'd109};   3: v = {8'd136,8'd34,8'd106};
        4: v = {8'd186,8'd54,8'd85};   5: v = {8'd227,8'd89,8'd51};
        6: v = {8'd249,8'd140,8'd10};  7: v = {8'd249,8'd201,8'd50};
        default: v = {8'd252,8'd255,8'd164};
      endcase
      5'd3: case (k)
        0: v = {8'd0,8'd0,8'd4};       1: v = {8'd28,8'd16,8'd68};
        2: v = {8'd79,8'd18,8'd123};   3: v = {8'd129,8'd37,8'd129};
        4: v = {8'd181,8'd54,8'd122};  5: v = {8'd229,8'd80,8'd100};
        6: v = {8'd251,8'd135,8'd97};  7: v = {8'd254,8'd194,8'd135};
        default: v = {8'd252,8'd253,8'd191};
      endcase
      5'd4: case (k)
        0: v = {8'd13,8'd8,8'd135};    1: v = {8'd75,8'd3,8'd161};
        2: v = {8'd125,8'd3,8'd168};   3: v = {8'd168,8'd34,8'd150};
        4: v = {8'd203,8'd70,8'd121};  5: v = {8'd229,8'd107,8'd93};
        6: v = {8'd248,8'd148,8'd65};  7: v = {8'd253,8'd195,8'd40};
        default: v = {8'd240,8'd249,8'd33};
      endcase
      5'd5: case (k)
        0: v = {8'd0,8'd34,8'd78};     1: v = {8'd38,8'd62,8'd110};
        2: v = {8'd73,8'd82,8'd112};   3: v = {8'd108,8'd103,8'd109};
        4: v = {8'd146,8'd123,8'd103}; 5: v = {8'd187,8'd145,8'd87};
        6: v = {8'd225,8'd170,8'd61};  default: v = {8'd255,8'd221,8'd57};
      endcase
      5'd6: case (k)
        0: v = {8'd48,8'd18,8'd59};    1: v = {8'd64,8'd90,8'd210};
        2: v = {8'd28,8'd168,8'd232};  3: v = {8'd36,8'd231,8'd138};
        4: v = {8'd166,8'd249,8'd40};  5: v = {8'd250,8'd186,8'd30};
        6: v = {8'd232,8'd79,8'd12};   default: v = {8'd122,8'd4,8'd3};
      endcase
      5'd7: case (k)
        0: v = {8'd0,8'd0,8'd128};     1: v = {8'd0,8'd0,8'd255};
        2: v = {8'd0,8'd255,8'd255};   3: v = {8'd255,8'd255,8'd0};
        4: v = {8'd255,8'd0,8'd0};     default: v = {8'd128,8'd0,8'd0};
      endcase
      5'd8: case (k)
        0: v = {8'd0,8'd0,8'd0};       1: v = {8'd255,8'd0,8'd0};
        2: v = {8'd255,8'd255,8'd0};   default: v = {8'd255,8'd255,8'd255};
      endcase
      5'd9: v = (k == 0) ? {8'd0,8'd255,8'd255} : {8'd255,8'd0,8'd255};
      5'd10: case (k)
        0: v = {8'd247,8'd251,8'd255}; 1: v = {8'd198,8'd219,8'd239};
        2: v = {8'd158,8'd202,8'd225}; 3: v = {8'd107,8'd174,8'd214};
        4: v = {8'd66,8'd146,8'd198};  5: v = {8'd33,8'd113,8'd181};
        6: v = {8'd8,8'd81,8'd156};    default: v = {8'd8,8'd48,8'd107};
      endcase
      5'd11: case (k)
        0: v = {8'd247,8'd252,8'd245}; 1: v = {8'd199,8'd233,8'd192};
        2: v = {8'd161,8'd217,8'd155}; 3: v = {8'd116,8'd196,8'd118};
        4: v = {8'd65,8'd171,8'd93};   5: v = {8'd35,8'd139,8'd69};
        6: v = {8'd0,8'd109,8'd44};    default: v = {8'd0,8'd68,8'd27};
      endcase
      5'd12: case (k)
        0: v = {8'd255,8'd245,8'd240}; 1: v = {8'd252,8'd187,8'd161};
        2: v = {8'd252,8'd146,8'd114}; 3: v = {8'd251,8'd106,8'd74};
        4: v = {8'd239,8'd59,8'd44};   5: v = {8'd203,8'd24,8'd29};
        6: v = {8'd165,8'd15,8'd21};   default: v = {8'd103,8'd0,8'd13};
      endcase
      5'd13: case (k)
        0: v = {8'd255,8'd245,8'd235}; 1: v = {8'd253,8'd208,8'd162};
        2: v = {8'd253,8'd174,8'd107}; 3: v = {8'd253,8'd141,8'd60};
        4: v = {8'd241,8'd105,8'd19};  5: v = {8'd217,8'd72,8'd1};
        6: v = {8'd166,8'd54,8'd3};    default: v = {8'd127,8'd39,8'd4};
      endcase
      5'd14: case (k)
        0: v = {8'd158,8'd1,8'd66};    1: v = {8'd213,8'd62,8'd79};
        2: v = {8'd244,8'd109,8'd67};  3: v = {8'd253,8'd174,8'd97};
        4: v = {8'd254,8'd224,8'd139}; 5: v = {8'd255,8'd255,8'd191};
        6: v = {8'd230,8'd245,8'd152}; 7: v = {8'd171,8'd221,8'd164};
        8: v = {8'd102,8'd194,8'd165}; 9: v = {8'd50,8'd136,8'd189};
        default: v = {8'd94,8'd79,8'd162};
      endcase
      5'd15: case (k)
        0: v = {8'd103,8'd0,8'd31};    1: v = {8'd178,8'd24,8'd43};
        2: v = {8'd214,8'd96,8'd77};   3: v = {8'd244,8'd165,8'd130};
        4: v = {8'd253,8'd219,8'd199}; 5: v = {8'd247,8'd247,8'd247};
        6: v = {8'd209,8'd229,8'd240}; 7: v = {8'd146,8'd197,8'd222};
        8: v = {8'd67,8'd147,8'd195};  9: v = {8'd33,8'd102,8'd172};
        default: v = {8'd5,8'd48,8'd97};
      endcase
      5'd16: case (k)
        0: v = {8'd165,8'd0,8'd38};    1: v = {8'd215,8'd48,8'd39};
        2: v = {8'd244,8'd109,8'd67};  3: v = {8'd253,8'd174,8'd97};
        4: v = {8'd254,8'd224,8'd144}; 5: v = {8'd255,8'd255,8'd191};
        6: v = {8'd224,8'd243,8'd248}; 7: v = {8'd171,8'd217,8'd233};
        8: v = {8'd116,8'd173,8'd209}; 9: v = {8'd69,8'd117,8'd180};
        default: v = {8'd49,8'd54,8'd149};
      endcase
      5'd17: case (k)
        0: v = {8'd165,8'd0,8'd38};    1: v = {8'd215,8'd48,8'd39};
        2: v = {8'd244,8'd109,8'd67};  3: v = {8'd253,8'd174,8'd97};
        4: v = {8'd254,8'd224,8'd139}; 5: v = {8'd255,8'd255,8'd191};
        6: v = {8'd217,8'd239,8'd139}; 7: v = {8'd166,8'd217,8'd106};
        8: v = {8'd102,8'd189,8'd99};  9: v = {8'd26,8'd152,8'd80};
        default: v = {8'd0,8'd104,8'd55};
      endcase
      5'd18: case (k)
        0: v = {8'd59,8'd76,8'd192};   1: v = {8'd124,8'd159,8'd249};
        2: v = {8'd192,8'd212,8'd245}; 3: v = {8'd242,8'd242,8'd242};
        4: v = {8'd246,8'd194,8'd165}; 5: v = {8'd222,8'd96,8'd77};
        default: v = {8'd180,8'd4,8'd38};
      endcase
      default: v = (k == 0) ? 24'h000000 : 24'hFFFFFF;
    endcase
    return v;
  endfunction

  function automatic int table_size(input logic [4:0] sel);
    case (sel)
      5'd1: return 10;
      5'd2, 5'd3, 5'd4: return 9;
      5'd5, 5'd6, 5'd10, 5'd11, 5'd12, 5'd13: return 8;
      5'd7: return 6;
      5'd8: return 4;
      5'd14, 5'd15, 5'd16, 5'd17: return 11;
      5'd18: return 7;
      default: return 2;
    endcase
  endfunction

  function automatic logic [7:0] mix(input int x, input int y, input longint f);
    longint acc;
    acc = longint'(x) * ONE + longint'(y - x) * f + ONE / 2;
    if (acc < 0) acc = 0;
    return 8'((acc >> 16) & 255);
  endfunction

  function automatic rgb_t sample_colour(input logic signed [17:0] tv);
    int t, n, i;
    bit own;
    longint scaled, f;
    logic [23:0] a, b;
    rgb_t c;
    t = tv;
    if (t < 0) t = 0;
    if (t > ONE) t = ONE;
    if (rev_q) t = ONE - t;
    n = (count_q > 8) ? 8 : count_q;
    own = (sel_q == MAP_CUSTOM) && (n >= 2);
    if (!own) n = table_size(sel_q);
    scaled = longint'(t) * (n - 1);
    f = scaled & (ONE - 1);
    i = int'(scaled >> 16);
    if (i >= n - 1) begin
      i = n - 1;
      f = 0;
    end
    if (own) begin
      a = 24'(pairs_q[i / 2] >> ((i % 2) * 24));
      b = (i + 1 < n) ? 24'(pairs_q[(i + 1) / 2] >> (((i + 1) % 2) * 24)) : a;
    end else begin
      a = table_colour(sel_q, i);
      b = (i + 1 < n) ? table_colour(sel_q, i + 1) : a;
    end
    c.r = mix(a[23:16], b[23:16], f);
    c.g = mix(a[15:8], b[15:8], f);
    c.b = mix(a[7:0], b[7:0], f);
    return c;
  endfunction

  assign colours_pending = colour_q.size();

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      sel_q <= MAP_GRAY;
      rev_q <= 1'b0;
      count_q <= '0;
      for (int k = 0; k < 4; k++) pairs_q[k] <= '0;
      colour_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) colour_q.push_back(sample_colour(in_data));
      if (out_valid && out_ready) begin
        if (colour_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected colour %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = colour_q.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10)
              $display("colour mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                       want.r, want.g, want.b, out_data[23:16], out_data[15:8],
                       out_data[7:0]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_SELECT:    sel_q <= cfg_data[4:0];
          REG_REVERSE_ORDER: rev_q <= cfg_data[0];
          REG_ANCHOR_COUNT:  count_q <= cfg_data[3:0];
          REG_PAIR_0:        pairs_q[0] <= cfg_data;
          REG_PAIR_1:        pairs_q[1] <= cfg_data;
          REG_PAIR_2:        pairs_q[2] <= cfg_data;
          REG_PAIR_3:        pairs_q[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/colormap_sampler_test.sv =====
module colormap_sampler_test;
  import cms_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   colours_pending;
  int   idle_cycles = 0;
  bit   timed_out = 1'b0;
  bit   stall_on = 1'b0;

  cms_stream_if #(.W(18)) in_ch ();
  cms_stream_if #(.W(24)) out_ch ();
  cms_cfg_if cfg ();

  always #5 clk = ~clk;

  colormap_sampler u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

  colormap_sampler_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index),
    .cfg_data(cfg.data), .fail_count(fail_count), .colours_pending(colours_pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_MAP_SELECT;
    cfg.data = '0;
  end

  // Receiver: alternate stretches of steady ready with stretches of random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_on = ~stall_on;
      out_ch.ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || cfg.valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  // Drop valid after each write so no two writes share a step.
  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold valid across a run of beats; drop it only for a gap.
  int burst_left = 0;
  task automatic send_t(input logic [17:0] tv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= tv;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (colours_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [17:0] random_t();
    case ($urandom_range(0, 9))
      0: return 18'($urandom);
      1: return 18'($urandom_range(0, 3) * 65536 / 3);
      2: return 18'h10000;
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic run_phase(input logic [4:0] sel, input bit rev, input logic [3:0] cnt,
                           input int items);
    write_reg(REG_MAP_SELECT, 48'(sel));
    write_reg(REG_REVERSE_ORDER, 48'(rev));
    write_reg(REG_ANCHOR_COUNT, 48'(cnt));
    for (int k = 0; k < 4; k++)
      write_reg(cfg_reg_t'(REG_PAIR_0 + k), 48'({$urandom, $urandom}));
    for (int k = 0; k < items; k++) send_t(random_t());
    drain();
  endtask

  initial begin
    logic [17:0] edges [12];
    edges = '{18'h20000, 18'h3FFFF, 18'h0, 18'h1, 18'h8000, 18'hFFFF, 18'h10000,
              18'h10001, 18'h1FFFF, 18'h15555, 18'h0AAAA, 18'h2AAAA};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      begin
        // Clamping and rounding on the reset map, then reversed jet.
        foreach (edges[k]) send_t(edges[k]);
        drain();
        write_reg(REG_MAP_SELECT, 48'd7);
        write_reg(REG_REVERSE_ORDER, 48'd1);
        foreach (edges[k]) send_t(edges[k]);
        drain();
        // Unknown register index must leave the map alone.
        write_reg(REG_UNUSED, 48'hFFFFFFFFFFFF);
        for (int k = 0; k < 4; k++) send_t(18'($urandom_range(0, 65536)));
        drain();
        run_phase(MAP_CUSTOM, 1'b0, 4'd8, 30);
        run_phase(MAP_CUSTOM, 1'b1, 4'd15, 30);
        run_phase(MAP_CUSTOM, 1'b0, 4'd1, 20);
        run_phase(MAP_CUSTOM, 1'b0, 4'd2, 20);
        run_phase(5'd31, 1'b0, 4'd0, 20);
        for (int p = 0; p < 40; p++)
          run_phase(5'($urandom_range(0, 31)), 1'($urandom), 4'($urandom_range(0, 15)), 30);
        run_phase(5'($urandom_range(0, 19)), 1'b1, 4'd5, 10);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
      end
      begin
        wait (timed_out);
        $display("Verification failed");
        $finish;
      end
    join
  end
endmodule

// ===== files.f =====
rtl/cms_pkg.sv
rtl/cms_stream_if.sv
rtl/cms_cfg_if.sv
rtl/cms_regs.sv
rtl/cms_blend.sv
rtl/colormap_sampler.sv
tb/colormap_sampler_checker.sv
tb/colormap_sampler_test.sv
